### hw/rtl/vp9_payload_descriptor_parser_core_macros.svh
// assertion macros used by the vp9 descriptor parser checker
`ifndef VP9_PAYLOAD_DESCRIPTOR_PARSER_CORE_MACROS_SVH
`define VP9_PAYLOAD_DESCRIPTOR_PARSER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define VP9PD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define VP9PD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/vp9pd_pkg.sv
// constants shared by the vp9 payload descriptor parser and its checker
package vp9pd_pkg;

	// first descriptor byte flags
	localparam logic [7:0] FLAG_I = 8'b1000_0000;
	localparam logic [7:0] FLAG_P = 8'b0100_0000;
	localparam logic [7:0] FLAG_L = 8'b0010_0000;
	localparam logic [7:0] FLAG_F = 8'b0001_0000;
	localparam logic [7:0] FLAG_B = 8'b0000_1000;
	localparam logic [7:0] FLAG_V = 8'b0000_0010;

	// picture id extension and reference chain bits
	localparam logic [7:0] BIT_M = 8'b1000_0000;
	localparam logic [7:0] BIT_N = 8'b0000_0001;

	// flexible-mode reference limit
	localparam logic [1:0] MAX_REFERENCES = 2'd3;

	// descriptor length field
	localparam int unsigned LEN_W = 11;
	localparam logic [LEN_W-1:0] LEN_MAX = 11'd1062;

	// status codes reported on payload end
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TRUNC   = 2'd1,
		ST_NO_DATA = 2'd2
	} status_t;

endpackage

### hw/rtl/vp9_payload_descriptor_parser_core.sv
// vp9 rtp payload descriptor parser: byte-wide walker with skid-buffered output
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  in       | in_valid/in_stall  | payload_byte, last_byte
//  out      | out_valid/out_stall| data_byte, is_frame_data, begins_frame,
//           |                    | payload_end, descriptor_length, status
//
// one beat per cycle sustained while out is not stalled; each result is registered in the result register or the skid
// the parse state updates in the accepting cycle, so the phase register sets the loop
// a two-entry output (result register plus skid) takes one more beat while out is stalled
// in_stall rises only when both output entries are full
// arst_n clears the parse state and empties the output stage; no clearing pass
module vp9_payload_descriptor_parser_core
	import vp9pd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       payload_byte,
	input  logic             last_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       data_byte,
	output logic             is_frame_data,
	output logic             begins_frame,
	output logic             payload_end,
	output logic [LEN_W-1:0] descriptor_length,
	output logic [1:0]       status
);

	typedef enum logic [3:0] {
		PH_FIRST   = 4'd0,
		PH_PID1    = 4'd1,
		PH_PID2    = 4'd2,
		PH_LAYER   = 4'd3,
		PH_TL0     = 4'd4,
		PH_REF     = 4'd5,
		PH_SS      = 4'd6,
		PH_RES_END = 4'd7,
		PH_RES_NG  = 4'd8,
		PH_NG      = 4'd9,
		PH_PG      = 4'd10,
		PH_DIFF    = 4'd11,
		PH_DATA    = 4'd12
	} phase_t;

	typedef struct packed {
		logic [7:0]       data;
		logic             frame;
		logic             begins;
		logic             last;
		logic [LEN_W-1:0] len;
		logic [1:0]       stat;
	} result_t;

	// descriptor routing helpers
	function automatic phase_t after_refs(input logic [7:0] f);
		return ((f & FLAG_V) != 8'd0) ? PH_SS : PH_DATA;
	endfunction

	function automatic phase_t after_layer(input logic [7:0] f);
		return (((f & FLAG_P) != 8'd0) && ((f & FLAG_F) != 8'd0)) ? PH_REF : after_refs(f);
	endfunction

	function automatic phase_t after_pid(input logic [7:0] f);
		return ((f & FLAG_L) != 8'd0) ? PH_LAYER : after_layer(f);
	endfunction

	phase_t           phase_q;
	logic [7:0]       flags_q;
	logic [5:0]       res_left_q;
	logic [7:0]       groups_q;
	logic [1:0]       diffs_q;
	logic [1:0]       refs_q;
	logic [LEN_W-1:0] len_q;

	result_t          main_q;
	result_t          skid_q;
	logic             main_v_q;
	logic             skid_v_q;

	phase_t           phase_nxt;
	logic [7:0]       flags_eff;
	logic [5:0]       res_nxt;
	logic [5:0]       res_dec;
	logic [7:0]       groups_nxt;
	logic [7:0]       groups_dec;
	logic [1:0]       diffs_nxt;
	logic [1:0]       diffs_dec;
	logic [1:0]       refs_nxt;
	logic [1:0]       refs_inc;
	logic [LEN_W-1:0] len_nxt;
	logic             was_data;
	status_t          stat_nxt;
	result_t          res;
	logic             accept_in;
	logic             take_out;

	// handshake
	assign accept_in = in_valid && !in_stall;
	assign take_out  = main_v_q && !out_stall;
	assign in_stall  = skid_v_q;

	// next parse state and result for the current beat
	always_comb begin
		flags_eff  = (phase_q == PH_FIRST) ? payload_byte : flags_q;
		was_data   = (phase_q > PH_DIFF);
		len_nxt    = (!was_data && (len_q < LEN_MAX)) ? len_q + 1'b1 : len_q;
		res_dec    = (res_left_q != 6'd0) ? res_left_q - 6'd1 : res_left_q;
		groups_dec = groups_q - 8'd1;
		diffs_dec  = diffs_q - 2'd1;
		refs_inc   = refs_q + 2'd1;
		phase_nxt  = phase_q;
		res_nxt    = res_left_q;
		groups_nxt = groups_q;
		diffs_nxt  = diffs_q;
		refs_nxt   = refs_q;

		unique case (phase_q)
			PH_FIRST: begin
				phase_nxt = ((payload_byte & FLAG_I) != 8'd0) ? PH_PID1 : after_pid(payload_byte);
			end
			PH_PID1: begin
				phase_nxt = ((payload_byte & BIT_M) != 8'd0) ? PH_PID2 : after_pid(flags_eff);
			end
			PH_PID2: begin
				phase_nxt = after_pid(flags_eff);
			end
			PH_LAYER: begin
				phase_nxt = ((flags_eff & FLAG_F) != 8'd0) ? after_layer(flags_eff) : PH_TL0;
			end
			PH_TL0: begin
				phase_nxt = after_layer(flags_eff);
			end
			PH_REF: begin
				refs_nxt = refs_inc;
				if (((payload_byte & BIT_N) == 8'd0) || (refs_inc >= MAX_REFERENCES)) begin
					phase_nxt = after_refs(flags_eff);
				end
			end
			PH_SS: begin
				if (payload_byte[4]) begin
					res_nxt   = {1'b0, payload_byte[7:5], 2'b00} + 6'd4;
					phase_nxt = payload_byte[3] ? PH_RES_NG : PH_RES_END;
				end else begin
					phase_nxt = payload_byte[3] ? PH_NG : PH_DATA;
				end
			end
			PH_RES_END, PH_RES_NG: begin
				res_nxt = res_dec;
				if (res_dec == 6'd0) begin
					phase_nxt = (phase_q == PH_RES_NG) ? PH_NG : PH_DATA;
				end
			end
			PH_NG: begin
				groups_nxt = payload_byte;
				phase_nxt  = (payload_byte != 8'd0) ? PH_PG : PH_DATA;
			end
			PH_PG: begin
				diffs_nxt = payload_byte[3:2];
				if (payload_byte[3:2] != 2'd0) begin
					phase_nxt = PH_DIFF;
				end else begin
					groups_nxt = groups_dec;
					phase_nxt  = (groups_dec != 8'd0) ? PH_PG : PH_DATA;
				end
			end
			PH_DIFF: begin
				diffs_nxt = diffs_dec;
				if (diffs_dec == 2'd0) begin
					groups_nxt = groups_dec;
					phase_nxt  = (groups_dec != 8'd0) ? PH_PG : PH_DATA;
				end
			end
			default: begin
				phase_nxt = PH_DATA;
			end
		endcase

		// reference counter restarts on entry to the reference list
		if ((phase_q != PH_REF) && (phase_nxt == PH_REF)) begin
			refs_nxt = 2'd0;
		end

		// end-of-payload status
		stat_nxt = ST_OK;
		if (last_byte) begin
			if (phase_nxt == PH_DATA) begin
				stat_nxt = was_data ? ST_OK : ST_NO_DATA;
			end else if ((phase_nxt == PH_REF) && ((flags_eff & FLAG_V) == 8'd0)) begin
				stat_nxt = ST_NO_DATA;
			end else begin
				stat_nxt = ST_TRUNC;
			end
		end

		res.data   = payload_byte;
		res.frame  = was_data;
		res.begins = ((flags_eff & FLAG_B) != 8'd0);
		res.last   = last_byte;
		res.len    = len_nxt;
		res.stat   = stat_nxt;
	end

	// parse state and output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			flags_q    <= 8'd0;
			res_left_q <= 6'd0;
			groups_q   <= 8'd0;
			diffs_q    <= 2'd0;
			refs_q     <= 2'd0;
			len_q      <= '0;
			main_q     <= '0;
			skid_q     <= '0;
			main_v_q   <= 1'b0;
			skid_v_q   <= 1'b0;
		end else begin
			// parse state, back to reset after a last beat
			if (accept_in) begin
				if (last_byte) begin
					phase_q    <= PH_FIRST;
					flags_q    <= 8'd0;
					res_left_q <= 6'd0;
					groups_q   <= 8'd0;
					diffs_q    <= 2'd0;
					refs_q     <= 2'd0;
					len_q      <= '0;
				end else begin
					phase_q    <= phase_nxt;
					flags_q    <= flags_eff;
					res_left_q <= res_nxt;
					groups_q   <= groups_nxt;
					diffs_q    <= diffs_nxt;
					refs_q     <= refs_nxt;
					len_q      <= len_nxt;
				end
			end

			// result register with skid entry behind it
			if (take_out || !main_v_q) begin
				if (skid_v_q) begin
					main_q   <= skid_q;
					main_v_q <= 1'b1;
					skid_v_q <= 1'b0;
				end else if (accept_in) begin
					main_q   <= res;
					main_v_q <= 1'b1;
				end else begin
					main_v_q <= 1'b0;
				end
			end else if (accept_in) begin
				skid_q   <= res;
				skid_v_q <= 1'b1;
			end
		end
	end

	// output ports
	assign out_valid         = main_v_q;
	assign data_byte         = main_q.data;
	assign is_frame_data     = main_q.frame;
	assign begins_frame      = main_q.begins;
	assign payload_end       = main_q.last;
	assign descriptor_length = main_q.len;
	assign status            = main_q.stat;

endmodule

### hw/rtl/vp9pd_checker.sv
// port-level checker for the vp9 payload descriptor parser, bound to the parser core
`include "vp9_payload_descriptor_parser_core_macros.svh"

module vp9pd_checker
	import vp9pd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic [7:0]       data_byte,
	input logic             is_frame_data,
	input logic             payload_end,
	input logic [LEN_W-1:0] descriptor_length,
	input logic [1:0]       status
);

	// status only carries news on the last beat of a payload
	`VP9PD_ASSERT_NOW(a_status_on_end, out_valid && !payload_end, status == ST_OK, "status set before payload end")

	// frame data only follows a descriptor of at least one byte
	`VP9PD_ASSERT_NOW(a_frame_after_desc, out_valid && is_frame_data, descriptor_length != '0, "frame data with empty descriptor")

	// length counter saturates
	`VP9PD_ASSERT_NOW(a_len_cap, out_valid, descriptor_length <= LEN_MAX, "descriptor length past its cap")

	// a stalled result beat holds
	`VP9PD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data_byte) && $stable(status), "stalled result beat changed")

endmodule

bind vp9_payload_descriptor_parser_core vp9pd_checker u_vp9pd_checker (.*);
